// File: sv/sync_length_deframer_core_assert.svh
// Assertion macros for the sync-length deframer core.
// Clocked on clk, disabled while arst_n is low; used by the top level only.
`ifndef SYNC_LENGTH_DEFRAMER_CORE_ASSERT_SVH
`define SYNC_LENGTH_DEFRAMER_CORE_ASSERT_SVH

// same-cycle implication
`define SLD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SLD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/sld_pkg.sv
// Shared types and constants for the sync-length deframer.
// No dependencies.
`timescale 1ns / 1ps
package sld_pkg;

	localparam logic [7:0] SYNC0       = 8'h57;
	localparam logic [7:0] SYNC1       = 8'h4C;
	localparam logic [7:0] VERSION_ONE = 8'h01;
	localparam logic [7:0] FLAG_KEEP   = 8'h03;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
	} sld_word_t;

	typedef struct packed {
		logic bursting;
		logic in_payload;
	} sld_status_t;

endpackage

// File: sv/sync_length_deframer_core.sv
// Sync-word, length-prefixed deframer: finds headers in a byte stream and
// emits whole frames (header, then payload) with first/last marks.
// Input side is a queue: write in_byte with push while full is low.
// Result side is a queue: out_byte, frame_first and frame_last are valid
// while empty is low; pop takes the word.
// Searching bytes are taken one per cycle until the window is full; each
// byte that completes the window is followed by the header and size check,
// during which full is high, so a sliding search stalls for every check.
// An accepted header is then replayed from the window, one word per cycle
// while the queue has room, HEADER_BYTES words in all; full stays high.
// Payload bytes are taken one per cycle while the queue is not full and
// reach the result ports through a four-word queue and then one output
// register, which sit between the front and the result ports.
// When pop stays low the queue fills and full rises; nothing is dropped.
// The user writes max_frame_bytes with max_frame_bytes_we only while idle;
// the block does not check it. Reset empties the window, queue and output
// register, leaves the block searching and sets max_frame_bytes to 4096.
// Depends on sld_pkg, sld_front, sld_queue, sld_back and the assert header.
`timescale 1ns / 1ps
module sync_length_deframer_core #(
	parameter int HEADER_BYTES = 24,
	parameter int MAX_FRAME    = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        max_frame_bytes_we,
	input  logic [12:0] max_frame_bytes,
	input  logic [7:0]  in_byte,
	input  logic        push,
	output logic        full,
	output logic [7:0]  out_byte,
	output logic        frame_first,
	output logic        frame_last,
	output logic        empty,
	input  logic        pop
);
	import sld_pkg::*;

	`include "sync_length_deframer_core_assert.svh"

	logic [12:0] max_q;
	sld_word_t   fq_word;
	logic        fq_push;
	logic        fq_full;
	sld_word_t   qb_word;
	logic        qb_empty;
	logic        qb_pop;
	sld_status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_q <= 13'd4096;
		else if (max_frame_bytes_we)
			max_q <= max_frame_bytes;
	end

	sld_front #(
		.HEADER_BYTES(HEADER_BYTES),
		.MAX_FRAME   (MAX_FRAME)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.max_frame_bytes(max_q),
		.in_byte        (in_byte),
		.push           (push),
		.full           (full),
		.q_word         (fq_word),
		.q_push         (fq_push),
		.q_full         (fq_full),
		.status         (status)
	);

	sld_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (fq_push),
		.word_in (fq_word),
		.full    (fq_full),
		.pop     (qb_pop),
		.word_out(qb_word),
		.empty   (qb_empty)
	);

	sld_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_word     (qb_word),
		.q_empty    (qb_empty),
		.q_pop      (qb_pop),
		.out_byte   (out_byte),
		.frame_first(frame_first),
		.frame_last (frame_last),
		.empty      (empty),
		.pop        (pop)
	);

	`SLD_ASSERT_IMP(a_burst_blocks_input, status.bursting, full, "input taken during header burst")
	`SLD_ASSERT_IMP(a_no_queue_overflow, fq_push, !fq_full, "word pushed into a full queue")
	`SLD_ASSERT_IMP(a_first_not_last, !empty && frame_first, !frame_last, "word marked first and last")
	`SLD_ASSERT_NXT(a_payload_word_queued, push && !full && status.in_payload, qb_empty == 1'b0, "payload word lost")

endmodule

// File: sv/sld_front.sv
// Front part: header window, header check and burst sequencer, payload pass.
// Depends on sld_pkg; feeds words into sld_queue.
`timescale 1ns / 1ps
module sld_front #(
	parameter int HEADER_BYTES = 24,
	parameter int MAX_FRAME    = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [12:0]        max_frame_bytes,
	input  logic [7:0]         in_byte,
	input  logic               push,
	output logic               full,
	output sld_pkg::sld_word_t q_word,
	output logic               q_push,
	input  logic               q_full,
	output sld_pkg::sld_status_t status
);
	import sld_pkg::*;

	localparam int IDX_W  = $clog2(HEADER_BYTES);
	localparam int LEFT_W = $clog2(MAX_FRAME + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HEADER_BYTES - 1);

	typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_BURST} state_t;

	state_t            state_q;
	logic [7:0]        window_q [HEADER_BYTES];
	logic [IDX_W-1:0]  fill_q;
	logic [IDX_W-1:0]  idx_q;
	logic [LEFT_W-1:0] len_q;
	logic [LEFT_W-1:0] payload_left_q;
	logic              in_payload_q;

	logic        accept;
	logic        hdr_ok;
	logic        frame_ok;
	logic [15:0] win_len;
	logic [16:0] total;
	logic [16:0] limit;

	assign full   = !(state_q == ST_IDLE && (!in_payload_q || !q_full));
	assign accept = push && !full;

	assign hdr_ok = window_q[0] == SYNC0 && window_q[1] == SYNC1 &&
			window_q[2] == VERSION_ONE && window_q[3] == 8'(HEADER_BYTES) &&
			(window_q[5] & ~FLAG_KEEP) == 8'h00;
	assign win_len  = {window_q[7], window_q[6]};
	assign total    = 17'(HEADER_BYTES) + {1'b0, win_len};
	assign limit    = ({4'b0, max_frame_bytes} > 17'(MAX_FRAME)) ? 17'(MAX_FRAME)
			: {4'b0, max_frame_bytes};
	assign frame_ok = hdr_ok && total <= limit;

	always_comb begin
		q_push = 1'b0;
		q_word = '{data: in_byte, first: 1'b0, last: payload_left_q <= LEFT_W'(1)};
		if (state_q == ST_BURST) begin
			q_push = !q_full;
			q_word = '{data: window_q[idx_q], first: idx_q == '0,
				last: idx_q == LAST_IDX && len_q == '0};
		end else if (state_q == ST_IDLE && accept && in_payload_q) begin
			q_push = 1'b1;
		end
	end

	assign status = '{bursting: state_q == ST_BURST, in_payload: in_payload_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			fill_q         <= '0;
			idx_q          <= '0;
			len_q          <= '0;
			in_payload_q   <= 1'b0;
			payload_left_q <= '0;
			for (int i = 0; i < HEADER_BYTES; i++)
				window_q[i] <= 8'h00;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_payload_q) begin
							payload_left_q <= payload_left_q - LEFT_W'(1);
							if (payload_left_q <= LEFT_W'(1))
								in_payload_q <= 1'b0;
						end else begin
							window_q[fill_q] <= in_byte;
							if (fill_q == LAST_IDX)
								state_q <= ST_CHECK;
							else
								fill_q <= fill_q + IDX_W'(1);
						end
					end
				end
				ST_CHECK: begin
					if (frame_ok) begin
						// length fits LEFT_W once the size check passed
						len_q   <= LEFT_W'(win_len);
						idx_q   <= '0;
						state_q <= ST_BURST;
					end else begin
						// drop oldest byte, window stays one short of full
						for (int i = 0; i < HEADER_BYTES - 1; i++)
							window_q[i] <= window_q[i + 1];
						state_q <= ST_IDLE;
					end
				end
				ST_BURST: begin
					if (!q_full) begin
						if (idx_q == LAST_IDX) begin
							fill_q         <= '0;
							in_payload_q   <= len_q != '0;
							payload_left_q <= len_q;
							state_q        <= ST_IDLE;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: sv/sld_queue.sv
// Short word queue between the front and back parts.
// Depends on sld_pkg.
`timescale 1ns / 1ps
module sld_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sld_pkg::sld_word_t word_in,
	output logic               full,
	input  logic               pop,
	output sld_pkg::sld_word_t word_out,
	output logic               empty
);
	import sld_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	sld_word_t        mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = count_q == CNT_W'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign word_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= word_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

// File: sv/sld_back.sv
// Back part: output register that drains the queue onto the result ports.
// Depends on sld_pkg.
`timescale 1ns / 1ps
module sld_back (
	input  logic               clk,
	input  logic               arst_n,
	input  sld_pkg::sld_word_t q_word,
	input  logic               q_empty,
	output logic               q_pop,
	output logic [7:0]         out_byte,
	output logic               frame_first,
	output logic               frame_last,
	output logic               empty,
	input  logic               pop
);
	import sld_pkg::*;

	sld_word_t word_q;
	logic      valid_q;

	// refill when the register is free or its word leaves this cycle
	assign q_pop = !q_empty && (!valid_q || pop);

	always_ff @(posedge clk) begin
		if (q_pop)
			word_q <= q_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			if (q_pop)
				valid_q <= 1'b1;
			else if (pop)
				valid_q <= 1'b0;
		end
	end

	assign empty       = !valid_q;
	assign out_byte    = word_q.data;
	assign frame_first = word_q.first;
	assign frame_last  = word_q.last;

endmodule

// File: test/sync_length_deframer_core_tb.sv
// Self-checking testbench for sync_length_deframer_core: byte stream in, frame words out.
// Uses sld_pkg for the sync constants and the word type; predicts frames on every
// accepted byte and checks each popped word in order.
`timescale 1ns / 1ps
module sync_length_deframer_core_tb;
	import sld_pkg::*;

	localparam int HDR        = 24;
	localparam int MAX_FRAME  = 4096;
	localparam int SETTLE     = 48;
	localparam int DRAIN_MAX  = 40000;
	localparam int LIMIT      = 3000000;

	typedef enum int {
		HDR_GOOD,
		HDR_ALL_FLAGS,
		HDR_BAD_SYNC0,
		HDR_BAD_SYNC1,
		HDR_BAD_VERSION,
		HDR_BAD_HLEN,
		HDR_BAD_FLAGS
	} hdr_kind_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        max_frame_bytes_we = 1'b0;
	logic [12:0] max_frame_bytes = 13'd0;
	logic [7:0]  in_byte = 8'h00;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  out_byte;
	logic        frame_first;
	logic        frame_last;
	logic        empty;
	logic        pop = 1'b0;

	// predictor state
	logic [7:0]  win [HDR];
	int unsigned fill = 0;
	bit          in_pay = 1'b0;
	int unsigned pay_left = 0;
	logic [12:0] max_bytes = 13'd4096;
	sld_word_t   frame_words [$];

	int          mismatches = 0;
	int          cycles = 0;
	int          tx_pct = 0;
	int          rx_pct = 0;
	int          rx_hold = 0;

	sync_length_deframer_core #(
		.HEADER_BYTES(HDR),
		.MAX_FRAME(MAX_FRAME)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.max_frame_bytes_we(max_frame_bytes_we),
		.max_frame_bytes(max_frame_bytes),
		.in_byte(in_byte),
		.push(push),
		.full(full),
		.out_byte(out_byte),
		.frame_first(frame_first),
		.frame_last(frame_last),
		.empty(empty),
		.pop(pop)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap(int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) == 0)
			return $urandom_range(12, 40);
		return $urandom_range(1, 3);
	endfunction

	// Advance the frame predictor by one accepted byte.
	function automatic void deframe_byte(logic [7:0] b);
		int unsigned len;
		int unsigned cap;
		sld_word_t w;
		bit hdr_valid;
		if (in_pay) begin
			w.data = b;
			w.first = 1'b0;
			w.last = (pay_left <= 1);
			if (pay_left > 0)
				pay_left--;
			if (pay_left == 0)
				in_pay = 1'b0;
			frame_words.push_back(w);
			return;
		end
		win[fill] = b;
		fill++;
		if (fill < HDR)
			return;
		len = {win[7], win[6]};
		cap = (max_bytes > MAX_FRAME) ? MAX_FRAME : max_bytes;
		hdr_valid = win[0] == SYNC0 && win[1] == SYNC1 && win[2] == VERSION_ONE &&
			win[3] == 8'(HDR) && (win[5] & ~FLAG_KEEP) == 8'h00;
		if (!hdr_valid || HDR + len > cap) begin
			// slide the search by one byte
			for (int i = 0; i < HDR - 1; i++)
				win[i] = win[i + 1];
			fill = HDR - 1;
			return;
		end
		for (int i = 0; i < HDR; i++) begin
			w.data = win[i];
			w.first = (i == 0);
			w.last = (len == 0 && i == HDR - 1);
			frame_words.push_back(w);
		end
		fill = 0;
		if (len != 0) begin
			in_pay = 1'b1;
			pay_left = len;
		end
	endfunction

	// Called at a clock edge; returns at the edge where the byte is taken.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap(tx_pct);
		if (gap > 0) begin
			push <= 1'b0;
			in_byte <= 8'($urandom);
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		in_byte <= b;
		do @(posedge clk); while (full);
		deframe_byte(b);
	endtask

	task automatic send_frame(input int unsigned len, input hdr_kind_t kind,
			input int unsigned npay);
		logic [7:0] h [HDR];
		foreach (h[i]) h[i] = 8'($urandom);
		h[0] = SYNC0;
		h[1] = SYNC1;
		h[2] = VERSION_ONE;
		h[3] = 8'(HDR);
		h[5] = 8'($urandom) & FLAG_KEEP;
		h[6] = len[7:0];
		h[7] = len[15:8];
		case (kind)
			HDR_ALL_FLAGS:   h[5] = FLAG_KEEP;
			HDR_BAD_SYNC0:   h[0] = SYNC0 ^ (8'h01 << $urandom_range(7));
			HDR_BAD_SYNC1:   h[1] = SYNC1 ^ (8'h01 << $urandom_range(7));
			HDR_BAD_VERSION: h[2] = VERSION_ONE ^ (8'h01 << $urandom_range(7));
			HDR_BAD_HLEN:    h[3] = 8'(HDR) ^ (8'h01 << $urandom_range(7));
			HDR_BAD_FLAGS:   h[5] = h[5] | (8'h04 << $urandom_range(5));
			default: ;
		endcase
		foreach (h[i]) send_byte(h[i]);
		repeat (npay) send_byte(8'($urandom));
	endtask

	// Idle the input and let every expected word drain, then the pipeline settle.
	task automatic settle();
		int waited;
		waited = 0;
		push <= 1'b0;
		while (frame_words.size() != 0 && waited < DRAIN_MAX) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_limit(input logic [12:0] v);
		settle();
		max_frame_bytes_we <= 1'b1;
		max_frame_bytes <= v;
		@(posedge clk);
		max_frame_bytes_we <= 1'b0;
		max_bytes = v;
	endtask

	// runs on the reset value of the size limit
	task automatic test_min_frames();
		tx_pct = 0;
		rx_pct = 0;
		send_frame(0, HDR_GOOD, 0);
		// all flag bits kept; a header inside a payload is just data
		send_frame(HDR, HDR_ALL_FLAGS, 0);
		send_frame(0, HDR_GOOD, 0);
	endtask

	// bad headers back to back; the search slides across all of them
	task automatic test_bad_headers();
		hdr_kind_t k;
		tx_pct = 20;
		rx_pct = 20;
		for (k = HDR_BAD_SYNC0; k <= HDR_BAD_FLAGS; k = hdr_kind_t'(k + 1))
			send_frame(0, k, 0);
	endtask

	task automatic test_size_limit();
		tx_pct = 10;
		rx_pct = 10;
		set_limit(13'd30);
		send_frame(6, HDR_GOOD, 6);
		// limit below the header size rejects everything
		set_limit(13'd23);
		send_frame(0, HDR_GOOD, 0);
		// limit above MAX_FRAME saturates; one byte over is rejected
		set_limit(13'h1FFF);
		send_frame(MAX_FRAME - HDR + 1, HDR_GOOD, 0);
	endtask

	// header burst fills the queue while the receiver holds off
	task automatic test_backpressure();
		tx_pct = 0;
		rx_pct = 0;
		rx_hold = 300;
		send_frame(2, HDR_GOOD, 2);
	endtask

	task automatic test_random();
		logic [12:0] limits [2];
		int unsigned len;
		int phase_items;
		int r;
		int n;
		limits = '{13'd4096, 13'($urandom_range(24, 80))};
		for (int p = 0; p < 2; p++) begin
			set_limit(limits[p]);
			tx_pct = (p == 1) ? 30 : 10;
			rx_pct = (p == 1) ? 10 : 50;
			phase_items = 0;
			while (phase_items < 16) begin
				r = $urandom_range(99);
				if (r < 70) begin
					r = $urandom_range(9);
					len = (r < 6) ? $urandom_range(0, 8) : $urandom_range(9, 40);
					send_frame(len, HDR_GOOD, len);
					phase_items += HDR + len;
				end else if (r < 85) begin
					send_frame($urandom_range(0, 8),
						hdr_kind_t'($urandom_range(HDR_BAD_SYNC0, HDR_BAD_FLAGS)), 0);
					phase_items += HDR;
				end else begin
					n = $urandom_range(1, 6);
					repeat (n) send_byte(8'($urandom));
					phase_items += n;
				end
			end
		end
	endtask

	// receiver: random pop gaps plus a long hold-off on request
	initial begin : rx_side
		int gap;
		gap = 0;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				pop <= 1'b0;
				rx_hold--;
			end else if (gap > 0) begin
				pop <= 1'b0;
				gap--;
			end else begin
				pop <= 1'b1;
				gap = pick_gap(rx_pct);
			end
		end
	end

	// a word moves on an edge with pop high and empty low
	always @(posedge clk) begin
		sld_word_t w;
		if (arst_n && pop && !empty) begin
			if (frame_words.size() == 0) begin
				$error("word with nothing expected: out_byte %0h first %0b last %0b",
					out_byte, frame_first, frame_last);
				mismatches++;
			end else begin
				w = frame_words.pop_front();
				if (out_byte !== w.data) begin
					$error("out_byte: expected %0h, got %0h", w.data, out_byte);
					mismatches++;
				end
				if (frame_first !== w.first) begin
					$error("frame_first: expected %0b, got %0b", w.first, frame_first);
					mismatches++;
				end
				if (frame_last !== w.last) begin
					$error("frame_last: expected %0b, got %0b", w.last, frame_last);
					mismatches++;
				end
			end
		end
	end

	initial begin : watchdog
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : main
		foreach (win[i]) win[i] = 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_min_frames();
		test_bad_headers();
		test_size_limit();
		test_backpressure();
		test_random();
		settle();
		if (frame_words.size() != 0) begin
			$error("%0d expected words never arrived", frame_words.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
